@@ hdl/pvb_pkg.sv @@
// Shared types, constants and CORDIC tables for the phase vocoder bin block.
package pvb_pkg;

   localparam int FFT_SIZE = 1024;
   localparam int NBINS    = FFT_SIZE / 2 + 1;
   localparam int LOG2_FFT = $clog2(FFT_SIZE);
   localparam int ADDR_W   = $clog2(NBINS);
   localparam int BIN_W    = 13;
   localparam int HOP_W    = 14;
   localparam int TURN_W   = 24;
   localparam int ADV_SH   = TURN_W - LOG2_FFT;
   localparam int STEPS    = 18;
   localparam int VX_W     = 27;
   localparam int VZ_W     = 26;
   localparam int MAG_W    = 24;
   localparam int VEC_LAT  = STEPS + 1;
   localparam int ROT_LAT  = STEPS + 2;
   localparam int M4_IDX   = VEC_LAT + 3;
   localparam int META_LEN = M4_IDX + ROT_LAT + 1;

   localparam logic [15:0] CORDIC_K      = 16'd39797;
   localparam logic [HOP_W-1:0] HOP_RESET = HOP_W'(256);
   localparam logic signed [VZ_W-1:0] HALF_TURN    = VZ_W'(24'h800000);
   localparam logic signed [VZ_W-1:0] QUARTER_TURN = VZ_W'(24'h400000);

   typedef struct packed {
      logic [BIN_W-1:0]  bin;
      logic signed [15:0] re_a;
      logic signed [15:0] im_a;
      logic signed [15:0] re_b;
      logic signed [15:0] im_b;
      logic [15:0]       alpha;
      logic              first;
      logic              inb;
   } item_type;

   typedef struct packed {
      logic             valid;
      logic [BIN_W-1:0] bin;
      logic             inb;
      logic             first;
      logic [15:0]      alpha;
   } meta_type;

   function automatic logic signed [VZ_W-1:0] atan_turn(input int i);
      logic [21:0] v;
      case (i)
         0: v = 22'd2097152;
         1: v = 22'd1238021;
         2: v = 22'd654136;
         3: v = 22'd332050;
         4: v = 22'd166669;
         5: v = 22'd83416;
         6: v = 22'd41718;
         7: v = 22'd20860;
         8: v = 22'd10430;
         9: v = 22'd5215;
         10: v = 22'd2608;
         11: v = 22'd1304;
         12: v = 22'd652;
         13: v = 22'd326;
         14: v = 22'd163;
         15: v = 22'd81;
         16: v = 22'd41;
         17: v = 22'd20;
         default: v = 22'd0;
      endcase
      return $signed({{(VZ_W-22){1'b0}}, v});
   endfunction

endpackage

@@ hdl/pvb_front.sv @@
// Input register that takes requests and marks bins inside the stored half spectrum.
module pvb_front import pvb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BIN_W-1:0]    req_bin_index,
   input  logic signed [15:0]  req_re_a,
   input  logic signed [15:0]  req_im_a,
   input  logic signed [15:0]  req_re_b,
   input  logic signed [15:0]  req_im_b,
   input  logic [15:0]         req_alpha,
   input  logic                req_first_frame,
   input  logic                push_ok,
   output logic                fr_valid,
   output item_type            fr_item
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     take;

   assign req_stall = valid_ff && !push_ok;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !push_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.bin   <= req_bin_index;
         item_ff.re_a  <= req_re_a;
         item_ff.im_a  <= req_im_a;
         item_ff.re_b  <= req_re_b;
         item_ff.im_b  <= req_im_b;
         item_ff.alpha <= req_alpha;
         item_ff.first <= req_first_frame;
         item_ff.inb   <= (32'(req_bin_index) < NBINS);
      end
   end

   assign fr_valid = valid_ff;
   assign fr_item  = item_ff;

endmodule

@@ hdl/pvb_queue.sv @@
// Two-entry queue between the front register and the processing pipeline.
module pvb_queue import pvb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output item_type head
);

   item_type   slot_ff [0:1];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = slot_ff[rd_ff];
   assign wr_in     = push ? ~wr_ff : wr_ff;
   assign rd_in     = pop ? ~rd_ff : rd_ff;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

@@ hdl/pvb_vec.sv @@
// Pipelined vectoring CORDIC giving the scaled magnitude and the angle in turns.
module pvb_vec import pvb_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [15:0]      in_re,
   input  logic signed [15:0]      in_im,
   output logic signed [VX_W-1:0]  out_x,
   output logic [TURN_W-1:0]       out_ang
);

   logic signed [VX_W-1:0] x_ff [0:STEPS];
   logic signed [VX_W-1:0] y_ff [0:STEPS];
   logic signed [VZ_W-1:0] z_ff [0:STEPS];
   logic                   zero_ff [0:STEPS];
   logic signed [VX_W-1:0] x0, y0;
   logic signed [VZ_W-1:0] z0;

   always_comb begin
      x0 = $signed({{(VX_W-24){in_re[15]}}, in_re, 8'h00});
      y0 = $signed({{(VX_W-24){in_im[15]}}, in_im, 8'h00});
      z0 = '0;
      if (in_re < 0) begin
         x0 = -x0;
         y0 = -y0;
         z0 = HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0;
         y_ff[0]    <= y0;
         z_ff[0]    <= z0;
         zero_ff[0] <= (in_re == 0) && (in_im == 0);
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] < 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_turn(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_turn(i);
            end
         end
      end
   end

   assign out_x   = zero_ff[STEPS] ? '0 : x_ff[STEPS];
   assign out_ang = zero_ff[STEPS] ? '0 : z_ff[STEPS][TURN_W-1:0];

endmodule

@@ hdl/pvb_rot.sv @@
// Pipelined rotation CORDIC that turns a magnitude and a phase into a complex value.
module pvb_rot import pvb_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic [MAG_W-1:0]        in_mag,
   input  logic [TURN_W-1:0]       in_phase,
   output logic signed [VX_W-1:0]  out_c,
   output logic signed [VX_W-1:0]  out_s
);

   logic [MAG_W+15:0]      p_ff;
   logic [TURN_W-1:0]      ph_ff;
   logic signed [VX_W-1:0] x_ff [0:STEPS];
   logic signed [VX_W-1:0] y_ff [0:STEPS];
   logic signed [VZ_W-1:0] z_ff [0:STEPS];
   logic [MAG_W+16:0]      p_rnd;
   logic signed [VX_W-1:0] x0;
   logic signed [VZ_W-1:0] z0;

   always_comb begin
      p_rnd = {1'b0, p_ff} + (MAG_W+17)'(32768);
      x0    = $signed(VX_W'(p_rnd >> 16));
      z0    = $signed({{(VZ_W-TURN_W){ph_ff[TURN_W-1]}}, ph_ff});
      if (z0 > QUARTER_TURN) begin
         x0 = -x0;
         z0 = z0 - HALF_TURN;
      end else if (z0 < -QUARTER_TURN) begin
         x0 = -x0;
         z0 = z0 + HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff    <= in_mag * CORDIC_K;
         ph_ff   <= in_phase;
         x_ff[0] <= x0;
         y_ff[0] <= '0;
         z_ff[0] <= z0;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_turn(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_turn(i);
            end
         end
      end
   end

   assign out_c = x_ff[STEPS];
   assign out_s = y_ff[STEPS];

endmodule

@@ hdl/phase_vocoder_bin.sv @@
// Top level of the phase vocoder bin block with the phase store and the back pipeline.
// The block takes one request per clock while req_stall is low and returns one response
// per request, in order. A request passes through the input register, the queue, the
// 18-step vectoring and rotation CORDIC pipelines, the magnitude blend and the phase
// store access.
// A response stall freezes the whole back pipeline; a two-entry queue and the input
// register keep taking requests until they fill. The phase store is not cleared at reset.
module phase_vocoder_bin import pvb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [HOP_W-1:0]   csr_hop_length,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BIN_W-1:0]   req_bin_index,
   input  logic signed [15:0] req_re_a,
   input  logic signed [15:0] req_im_a,
   input  logic signed [15:0] req_re_b,
   input  logic signed [15:0] req_im_b,
   input  logic [15:0]        req_alpha,
   input  logic               req_first_frame,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BIN_W-1:0]   rsp_out_bin,
   output logic signed [15:0] rsp_out_re,
   output logic signed [15:0] rsp_out_im
);

   logic [HOP_W-1:0] hop_ff;
   logic             fr_valid, q_full, q_ne, push, pop, en;
   item_type         fr_item, head;
   meta_type         meta_ff [0:META_LEN-1];
   meta_type         meta0;

   logic signed [VX_W-1:0] xa, xb, rc, rs;
   logic [TURN_W-1:0]      aa, ab;
   logic [TURN_W-1:0]      aa1_ff, ab1_ff, aa2_ff, ab2_ff, aa3_ff, ab3_ff, aa4_ff, ab4_ff;
   logic [VX_W+14:0]       pa_ff, pb_ff;
   logic [MAG_W-1:0]       ma_ff, mb_ff, m_ff;
   logic [MAG_W+16:0]      qa_ff, qb_ff;
   logic [TURN_W-1:0]      adv_ff, adv4_ff, adv_in;
   logic [HOP_W+BIN_W-1:0] adv_prod;
   logic [47:0]            adv_wide;
   logic [MAG_W+17:0]      q_sum;

   logic [TURN_W-1:0] phase_mem [0:NBINS-1];
   logic [TURN_W-1:0] rd_ff, fwd_val_ff, ph_cur, ph_old, wval;
   logic              fwd_ff;

   logic               rsp_valid_ff;
   logic [BIN_W-1:0]   rsp_bin_ff;
   logic signed [15:0] rsp_re_ff, rsp_im_ff;

   function automatic logic signed [15:0] sat16(input logic signed [VX_W-1:0] v);
      logic signed [VX_W-1:0] r;
      r = (v + VX_W'(128)) >>> 8;
      if (r > VX_W'(32767)) begin
         return 16'sh7FFF;
      end else if (r < -VX_W'(32768)) begin
         return 16'sh8000;
      end
      return r[15:0];
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_ff <= HOP_RESET;
      end else if (csr_valid) begin
         hop_ff <= csr_hop_length;
      end
   end

   pvb_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_bin_index(req_bin_index), .req_re_a(req_re_a), .req_im_a(req_im_a),
      .req_re_b(req_re_b), .req_im_b(req_im_b), .req_alpha(req_alpha),
      .req_first_frame(req_first_frame), .push_ok(!q_full),
      .fr_valid(fr_valid), .fr_item(fr_item)
   );

   assign push = fr_valid && !q_full;
   assign en   = !rsp_valid_ff || !rsp_stall;
   assign pop  = en && q_ne;

   pvb_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_item(fr_item), .full(q_full),
      .pop(pop), .not_empty(q_ne), .head(head)
   );

   pvb_vec u_vec_a (
      .clock(clock), .en(en), .in_re(head.re_a), .in_im(head.im_a),
      .out_x(xa), .out_ang(aa)
   );

   pvb_vec u_vec_b (
      .clock(clock), .en(en), .in_re(head.re_b), .in_im(head.im_b),
      .out_x(xb), .out_ang(ab)
   );

   always_comb begin
      meta0.valid = q_ne;
      meta0.bin   = head.bin;
      meta0.inb   = head.inb;
      meta0.first = head.first;
      meta0.alpha = head.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < META_LEN; i++) begin
            meta_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         meta_ff[0] <= meta0;
         for (int i = 1; i < META_LEN; i++) begin
            meta_ff[i] <= meta_ff[i-1];
         end
      end
   end

   assign adv_prod = hop_ff * meta_ff[M4_IDX-2].bin;
   assign adv_wide = 48'(adv_prod) << ADV_SH;
   assign adv_in   = adv_wide[TURN_W-1:0];
   assign q_sum    = {1'b0, qa_ff} + {1'b0, qb_ff} + (MAG_W+18)'(32768);

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff   <= $unsigned(xa[VX_W-2:0]) * CORDIC_K;
         pb_ff   <= $unsigned(xb[VX_W-2:0]) * CORDIC_K;
         aa1_ff  <= aa;
         ab1_ff  <= ab;
         ma_ff   <= MAG_W'((pa_ff + (VX_W+15)'(32768)) >> 16);
         mb_ff   <= MAG_W'((pb_ff + (VX_W+15)'(32768)) >> 16);
         aa2_ff  <= aa1_ff;
         ab2_ff  <= ab1_ff;
         qa_ff   <= ma_ff * (17'h10000 - {1'b0, meta_ff[M4_IDX-2].alpha});
         qb_ff   <= mb_ff * {1'b0, meta_ff[M4_IDX-2].alpha};
         adv_ff  <= adv_in;
         aa3_ff  <= aa2_ff;
         ab3_ff  <= ab2_ff;
         m_ff    <= MAG_W'(q_sum >> 16);
         adv4_ff <= adv_ff;
         aa4_ff  <= aa3_ff;
         ab4_ff  <= ab3_ff;
      end
   end

   assign ph_old = fwd_ff ? fwd_val_ff : rd_ff;
   assign ph_cur = meta_ff[M4_IDX].first ? aa4_ff : ph_old;
   assign wval   = ph_cur + adv4_ff + (ab4_ff - aa4_ff - adv4_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff      <= phase_mem[meta_ff[M4_IDX-1].bin[ADDR_W-1:0]];
         fwd_ff     <= meta_ff[M4_IDX].valid && meta_ff[M4_IDX].inb &&
                       (meta_ff[M4_IDX].bin == meta_ff[M4_IDX-1].bin);
         fwd_val_ff <= wval;
         if (meta_ff[M4_IDX].valid && meta_ff[M4_IDX].inb) begin
            phase_mem[meta_ff[M4_IDX].bin[ADDR_W-1:0]] <= wval;
         end
      end
   end

   pvb_rot u_rot (
      .clock(clock), .en(en), .in_mag(m_ff), .in_phase(ph_cur),
      .out_c(rc), .out_s(rs)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= meta_ff[META_LEN-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_bin_ff <= meta_ff[META_LEN-1].bin;
         rsp_re_ff  <= meta_ff[META_LEN-1].inb ? sat16(rc) : '0;
         rsp_im_ff  <= meta_ff[META_LEN-1].inb ? sat16(rs) : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_bin = rsp_bin_ff;
   assign rsp_out_re  = rsp_re_ff;
   assign rsp_out_im  = rsp_im_ff;

endmodule
